@@ hw/rtl/csfc_pkg.sv @@
// Package of shared types and constants for the colour sensor frequency classifier.
`timescale 1ns / 1ps

package csfc_pkg;

	localparam int StampW = 16;
	localparam int FilterW = 2;
	localparam int FreqW = 20;
	localparam int ClassW = 2;
	localparam int GainW = 8;
	localparam int MarginW = 16;
	localparam int ProdW = FreqW + GainW;
	localparam int SumW = ProdW + 1;
	localparam int DivSteps = FreqW;
	localparam int DefaultQueueDepth = 2;

	localparam logic [FreqW-1:0] FreqScale = 20'd1000000;
	localparam logic [StampW-1:0] WrapSpan = 16'hFFFF;
	localparam logic [FreqW-1:0] RedOffset = 20'd100;
	localparam logic [FreqW-1:0] BlueRedOffset = 20'd95;

	localparam logic [GainW-1:0] GainReset = 8'd1;
	localparam logic [MarginW-1:0] MarginReset = 16'd100;

	localparam logic [FilterW-1:0] FILTER_RED = 2'd0;
	localparam logic [FilterW-1:0] FILTER_GREEN = 2'd1;
	localparam logic [FilterW-1:0] FILTER_BLUE = 2'd2;
	localparam logic [FilterW-1:0] FILTER_NONE = 2'd3;

	localparam logic [ClassW-1:0] CLASS_RED = 2'd0;
	localparam logic [ClassW-1:0] CLASS_GREEN = 2'd1;
	localparam logic [ClassW-1:0] CLASS_BLUE = 2'd2;
	localparam logic [ClassW-1:0] CLASS_MIXED = 2'd3;

	localparam logic [1:0] CFG_GREEN_GAIN = 2'd0;
	localparam logic [1:0] CFG_BLUE_GAIN = 2'd1;
	localparam logic [1:0] CFG_MARGIN = 2'd2;

	typedef struct packed {
		logic [StampW-1:0] capture_time;
		logic [FilterW-1:0] filter_sel;
	} in_item_t;

	typedef struct packed {
		logic [FilterW-1:0] filter_out;
		logic [FreqW-1:0] freq_value;
		logic [ClassW-1:0] color_class;
		logic zero_period;
	} out_item_t;

	typedef struct packed {
		logic [FilterW-1:0] sel;
		logic [StampW-1:0] period;
		logic zero;
	} job_t;

	typedef struct packed {
		logic [GainW-1:0] green_gain;
		logic [GainW-1:0] blue_gain;
		logic [MarginW-1:0] margin;
	} cfg_t;

endpackage

@@ hw/rtl/csfc_front.sv @@
// Front end: pairs capture stamps and forms the period of each completed pair.
`timescale 1ns / 1ps

module csfc_front
	import csfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     push,
	output job_t     job,
	input  logic     queue_full
);

	logic awaiting_q;
	logic [StampW-1:0] first_stamp_q;
	logic accept;
	logic usable;

	assign in_stall = queue_full;
	assign accept = in_valid && !in_stall;
	assign usable = accept && (in_data.filter_sel != FILTER_NONE);
	assign push = usable && awaiting_q;

	always_comb begin
		job.sel = in_data.filter_sel;
		if (in_data.capture_time > first_stamp_q) begin
			job.period = in_data.capture_time - first_stamp_q;
		end else begin
			job.period = (WrapSpan - first_stamp_q) + in_data.capture_time;
		end
		job.zero = (job.period == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			first_stamp_q <= '0;
		end else if (usable) begin
			if (!awaiting_q) begin
				first_stamp_q <= in_data.capture_time;
			end
			awaiting_q <= !awaiting_q;
		end
	end

	a_push_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> awaiting_q && (job.sel != FILTER_NONE))
		else $error("period pushed without a held first stamp");

endmodule

@@ hw/rtl/csfc_queue.sv @@
// Short job queue between the front end and the divider back end.
`timescale 1ns / 1ps

module csfc_queue
	import csfc_pkg::*;
#(
	parameter int Depth = DefaultQueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic head_valid,
	output job_t head_job,
	input  logic pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond its depth");

endmodule

@@ hw/rtl/csfc_back.sv @@
// Back end: bit-serial divider, per-filter frequency store and classifier.
`timescale 1ns / 1ps

module csfc_back
	import csfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	input  job_t      job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_CMP
	} state_t;

	localparam int CntW = $clog2(DivSteps);

	state_t state_q;
	logic [FilterW-1:0] sel_q;
	logic zero_q;
	logic [StampW-1:0] divisor_q;
	logic [StampW-1:0] rem_q;
	logic [FreqW-1:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic [FreqW-1:0] chan_q [3];
	logic [FreqW-1:0] r_q;
	logic [ProdW-1:0] g_q;
	logic [ProdW-1:0] b_q;
	logic [FreqW:0] r_red_q;
	logic [FreqW:0] r_blue_q;
	logic [FreqW:0] rm_q;
	logic [SumW-1:0] gm_q;
	logic [SumW-1:0] bm_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [StampW:0] rem_shift;
	logic div_ge;
	logic [StampW-1:0] rem_next;
	logic [FreqW-1:0] r_new;
	logic [FreqW-1:0] g_new;
	logic [FreqW-1:0] b_new;
	logic [ClassW-1:0] cls;

	assign pop = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// One restoring step per cycle; quo_q shifts the dividend out and quotient bits in.
	always_comb begin
		rem_shift = {rem_q, quo_q[FreqW-1]};
		div_ge = (rem_shift >= {1'b0, divisor_q});
		rem_next = div_ge ? StampW'(rem_shift - {1'b0, divisor_q}) : rem_shift[StampW-1:0];
	end

	always_comb begin
		r_new = (sel_q == FILTER_RED) ? quo_q : chan_q[0];
		g_new = (sel_q == FILTER_GREEN) ? quo_q : chan_q[1];
		b_new = (sel_q == FILTER_BLUE) ? quo_q : chan_q[2];
	end

	always_comb begin
		if ((SumW'(r_red_q) > gm_q) && (SumW'(r_blue_q) > bm_q)) begin
			cls = CLASS_RED;
		end else if ((SumW'(g_q) > SumW'(rm_q)) && (SumW'(g_q) > bm_q)) begin
			cls = CLASS_GREEN;
		end else if ((SumW'(b_q) > SumW'(rm_q)) && (SumW'(b_q) > gm_q)) begin
			cls = CLASS_BLUE;
		end else begin
			cls = CLASS_MIXED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= '0;
			zero_q <= 1'b0;
			divisor_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			r_q <= '0;
			g_q <= '0;
			b_q <= '0;
			r_red_q <= '0;
			r_blue_q <= '0;
			rm_q <= '0;
			gm_q <= '0;
			bm_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			chan_q[0] <= '0;
			chan_q[1] <= '0;
			chan_q[2] <= '0;
		end else begin
			// A result that leaves while the next one is loaded keeps valid high.
			if (out_valid_q && !out_stall && (state_q != ST_CMP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						sel_q <= job.sel;
						zero_q <= job.zero;
						divisor_q <= job.period;
						rem_q <= '0;
						quo_q <= FreqScale;
						cnt_q <= '0;
						state_q <= job.zero ? ST_MUL : ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[FreqW-2:0], div_ge};
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (sel_q == FILTER_RED) begin
						chan_q[0] <= quo_q;
					end
					if (sel_q == FILTER_GREEN) begin
						chan_q[1] <= quo_q;
					end
					if (sel_q == FILTER_BLUE) begin
						chan_q[2] <= quo_q;
					end
					r_q <= r_new;
					g_q <= g_new * cfg.green_gain;
					b_q <= b_new * cfg.blue_gain;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					r_red_q <= (FreqW + 1)'(r_q) + (FreqW + 1)'(RedOffset);
					r_blue_q <= (FreqW + 1)'(r_q) + (FreqW + 1)'(BlueRedOffset);
					rm_q <= (FreqW + 1)'(r_q) + (FreqW + 1)'(cfg.margin);
					gm_q <= SumW'(g_q) + SumW'(cfg.margin);
					bm_q <= SumW'(b_q) + SumW'(cfg.margin);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!out_valid_q || !out_stall) begin
						out_q.filter_out <= sel_q;
						out_q.freq_value <= quo_q;
						out_q.color_class <= cls;
						out_q.zero_period <= zero_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CntW'(DivSteps - 1)))
		else $error("divider step count out of range");

	a_zero_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.zero_period) |-> (out_q.freq_value == FreqScale))
		else $error("zero period result not saturated");

endmodule

@@ hw/rtl/color_sensor_frequency_classifier_unit.sv @@
// Top level of the colour sensor frequency classifier.
`timescale 1ns / 1ps

// Timer capture stamps arrive one per transfer, each tagged with the active colour
// filter; the filter code three is dropped without touching any state. The first
// stamp of a pair is held and yields nothing, the second completes the pair and
// yields one result: the filter, the frequency 1000000 / period (saturated to
// 1000000 with zero_period set when the period is zero), and a red, green, blue or
// mixed verdict over the three stored frequencies, green and blue scaled by their
// gains. A completed pair passes through a short job queue to the back end, which
// takes the job, runs the one-bit-per-cycle divider, then forms the gain products,
// the margin sums and the comparisons, taking no new job until the result is
// registered; a zero period skips the divider. The divider sets the sustained
// rate. The queue and the output register let the front end keep taking stamps,
// until the queue fills, while the back end divides or a result waits for its
// transfer. Gains and margin are written through the configuration channel,
// which is always ready, and should only be changed while no pair is in flight.

module color_sensor_frequency_classifier_unit
	import csfc_pkg::*;
#(
	parameter int QueueDepth = DefaultQueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [MarginW-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic queue_full;
	logic head_valid;
	job_t head_job;
	logic pop;

	// Register writes complete in the cycle they are offered; an index beyond
	// the three registers is accepted and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_gain <= GainReset;
			cfg_q.blue_gain <= GainReset;
			cfg_q.margin <= MarginReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GREEN_GAIN: cfg_q.green_gain <= cfg_data[GainW-1:0];
				CFG_BLUE_GAIN:  cfg_q.blue_gain <= cfg_data[GainW-1:0];
				CFG_MARGIN:     cfg_q.margin <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: pairing of stamps and period arithmetic, one stamp per cycle while the queue is not full.
	csfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push       (push),
		.job        (push_job),
		.queue_full (queue_full)
	);

	// Decoupling queue of periods awaiting division.
	csfc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	// Back end: division, frequency store, classification and output register.
	csfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
